// ----- rtl/core/tvwt_pkg.sv -----
// tvwt_pkg: sizes, types and constants of the tolerance vertex weld table
// no dependencies; imported by tolerance_vertex_weld_table and its testbench
package tvwt_pkg;

    // store geometry
    localparam int MAX_VERTICES = 1024;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

    // field widths
    localparam int COORD_W   = 32;
    localparam int TOL_W     = 31;
    localparam int IDX_OUT_W = 10;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int SQ_W      = 2 * TOL_W;
    localparam int SUM_W     = 64;

    typedef logic [ADDR_W-1:0]         addr_t;
    typedef logic [CNT_W-1:0]          count_t;
    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [TOL_W-1:0]          tol_t;
    typedef logic [IDX_OUT_W-1:0]      idx_out_t;
    typedef logic [3*COORD_W-1:0]      entry_t;

    localparam count_t MAX_COUNT = count_t'(MAX_VERTICES);

endpackage

// ----- rtl/core/tolerance_vertex_weld_table.sv -----
// tolerance_vertex_weld_table: vertex store with tolerance search and append
// depends on tvwt_pkg (sizes, types, constants)
//
// Each accepted word is one Q16.16 vertex. With merge_enable set, the stored
// vertices are read one per cycle from a single-port memory (one read or one
// write per cycle) and pass a four-stage pipeline: memory read, per-axis
// absolute difference with a box test against the tolerance, squares, and
// sum; the sum is then compared with the squared tolerance. The first match in
// index order wins and stops the scan. With no match, the vertex is appended,
// or the result reports a full store. One item is worked on at a time; the
// result sits in an output register, so the next word is taken while it waits.
// The store needs no clearing after reset: only entries below the vertex count
// are ever read.
// Write the tolerance only while the block idles.
module tolerance_vertex_weld_table (
    input  logic              clk,
    input  logic              rst_n,
    // configuration write channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  tvwt_pkg::tol_t    cfg_data,
    // input channel
    input  logic              in_valid,
    output logic              in_ready,
    input  tvwt_pkg::coord_t  pos_x,
    input  tvwt_pkg::coord_t  pos_y,
    input  tvwt_pkg::coord_t  pos_z,
    input  logic              merge_enable,
    // output channel
    output logic              out_valid,
    input  logic              out_ready,
    output tvwt_pkg::idx_out_t vertex_index,
    output logic              is_new,
    output logic              store_full
);
    import tvwt_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_RESULT = 2'd2;

    // control state
    logic [1:0] state_reg, state_next;
    count_t     count_reg, count_next;
    count_t     issue_reg, issue_next;
    tol_t       tol_reg;
    logic [SQ_W-1:0] tol_sq_reg;

    // current vertex
    coord_t x_reg, y_reg, z_reg;

    // pipeline stages
    logic  s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    addr_t s1_idx_reg, s2_idx_reg, s3_idx_reg, s4_idx_reg;
    logic  s2_near_reg, s3_near_reg, s4_near_reg;
    tol_t  s2_dx_reg, s2_dy_reg, s2_dz_reg;
    logic [SQ_W-1:0]  s3_sqx_reg, s3_sqy_reg, s3_sqz_reg;
    logic [SUM_W-1:0] s4_sum_reg;

    // memory
    entry_t mem [MAX_VERTICES];
    entry_t rd_data_reg;
    logic   rd_en, wr_en;
    addr_t  rd_addr, wr_addr;

    // pending result
    addr_t res_idx_reg, res_idx_next;
    logic  res_new_reg, res_new_next;
    logic  res_full_reg, res_full_next;

    // output register
    logic     out_valid_reg;
    idx_out_t out_idx_reg;
    logic     out_new_reg, out_full_reg;

    logic in_fire, out_load, hit, issuing, pipe_empty;
    logic [DIFF_W-1:0] dx, dy, dz;
    coord_t mx, my, mz;

    assign cfg_ready  = 1'b1;
    assign in_ready   = (state_reg == ST_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign out_load   = (state_reg == ST_RESULT) && (!out_valid_reg || out_ready);
    assign issuing    = (issue_reg != count_reg);
    assign pipe_empty = !s1_valid_reg && !s2_valid_reg && !s3_valid_reg && !s4_valid_reg;
    assign hit        = s4_valid_reg && s4_near_reg
                        && (s4_sum_reg <= SUM_W'(tol_sq_reg));

    assign out_valid    = out_valid_reg;
    assign vertex_index = out_idx_reg;
    assign is_new       = out_new_reg;
    assign store_full   = out_full_reg;

    // sequencer: scan, append, hand over result
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        issue_next    = issue_reg;
        res_idx_next  = res_idx_reg;
        res_new_next  = res_new_reg;
        res_full_next = res_full_reg;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        rd_addr       = issue_reg[ADDR_W-1:0];
        wr_addr       = count_reg[ADDR_W-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_SCAN;
                    issue_next = merge_enable ? '0 : count_reg;
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    res_idx_next  = s4_idx_reg;
                    res_new_next  = 1'b0;
                    res_full_next = 1'b0;
                    state_next    = ST_RESULT;
                end
                else if (issuing)
                begin
                    rd_en      = 1'b1;
                    issue_next = issue_reg + 1'b1;
                end
                else if (pipe_empty)
                begin
                    state_next = ST_RESULT;
                    if (count_reg == MAX_COUNT)
                    begin
                        res_idx_next  = '0;
                        res_new_next  = 1'b0;
                        res_full_next = 1'b1;
                    end
                    else
                    begin
                        wr_en         = 1'b1;
                        count_next    = count_reg + 1'b1;
                        res_idx_next  = count_reg[ADDR_W-1:0];
                        res_new_next  = 1'b1;
                        res_full_next = 1'b0;
                    end
                end
            end
            ST_RESULT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            issue_reg     <= '0;
            tol_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            issue_reg    <= issue_next;
            if (cfg_valid && cfg_ready)
            begin
                tol_reg <= cfg_data;
            end
            s1_valid_reg <= rd_en;
            s2_valid_reg <= s1_valid_reg && !hit;
            s3_valid_reg <= s2_valid_reg && !hit;
            s4_valid_reg <= s3_valid_reg && !hit;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // vertex store, one access a cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {x_reg, y_reg, z_reg};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // stage 2 logic: absolute differences per axis
    assign mx = rd_data_reg[3*COORD_W-1:2*COORD_W];
    assign my = rd_data_reg[2*COORD_W-1:COORD_W];
    assign mz = rd_data_reg[COORD_W-1:0];

    function automatic logic [DIFF_W-1:0] abs_diff(input coord_t a, input coord_t b);
        logic signed [DIFF_W-1:0] d;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    endfunction

    assign dx = abs_diff(mx, x_reg);
    assign dy = abs_diff(my, y_reg);
    assign dz = abs_diff(mz, z_reg);

    // payload registers: vertex, pipeline data, results
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            x_reg <= pos_x;
            y_reg <= pos_y;
            z_reg <= pos_z;
        end
        tol_sq_reg   <= SQ_W'(tol_reg) * SQ_W'(tol_reg);
        // stage 1: address in flight
        s1_idx_reg   <= rd_addr;
        // stage 2: box test and clipped differences
        s2_idx_reg   <= s1_idx_reg;
        s2_near_reg  <= (dx <= DIFF_W'(tol_reg)) && (dy <= DIFF_W'(tol_reg))
                        && (dz <= DIFF_W'(tol_reg));
        s2_dx_reg    <= dx[TOL_W-1:0];
        s2_dy_reg    <= dy[TOL_W-1:0];
        s2_dz_reg    <= dz[TOL_W-1:0];
        // stage 3: squares
        s3_idx_reg   <= s2_idx_reg;
        s3_near_reg  <= s2_near_reg;
        s3_sqx_reg   <= SQ_W'(s2_dx_reg) * SQ_W'(s2_dx_reg);
        s3_sqy_reg   <= SQ_W'(s2_dy_reg) * SQ_W'(s2_dy_reg);
        s3_sqz_reg   <= SQ_W'(s2_dz_reg) * SQ_W'(s2_dz_reg);
        // stage 4: sum of squares
        s4_idx_reg   <= s3_idx_reg;
        s4_near_reg  <= s3_near_reg;
        s4_sum_reg   <= SUM_W'(s3_sqx_reg) + SUM_W'(s3_sqy_reg) + SUM_W'(s3_sqz_reg);
        // pending result
        res_idx_reg  <= res_idx_next;
        res_new_reg  <= res_new_next;
        res_full_reg <= res_full_next;
        if (out_load)
        begin
            out_idx_reg  <= IDX_OUT_W'(res_idx_reg);
            out_new_reg  <= res_new_reg;
            out_full_reg <= res_full_reg;
        end
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_COUNT)
        else $error("vertex count beyond store size");

    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (count_reg < MAX_COUNT))
        else $error("append into a full store");

    a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && hit) |-> (CNT_W'(s4_idx_reg) < count_reg))
        else $error("match on an entry never written");

    a_result_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_new_reg && out_full_reg))
        else $error("result both appended and full");

    a_append_counts: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("append did not advance the vertex count");

endmodule

// ----- sim/tolerance_vertex_weld_table_tb.sv -----
// tolerance_vertex_weld_table_tb: self-checking bench for the vertex weld table
// drives tolerance writes and, with random idling, vertex and result words; checks
// every result word against an in-bench weld predictor; needs tvwt_pkg and the rtl
`timescale 1ns / 100ps

module tolerance_vertex_weld_table_tb;
    import tvwt_pkg::*;

    typedef longint unsigned u64_t;

    typedef struct {
        coord_t x;
        coord_t y;
        coord_t z;
    } vertex_t;

    typedef struct {
        idx_out_t vertex_index;
        logic     is_new;
        logic     store_full;
    } weld_result_t;

    localparam coord_t C_MIN  = coord_t'(32'h8000_0000);
    localparam coord_t C_MAX  = coord_t'(32'h7FFF_FFFF);
    localparam coord_t C_HALF = coord_t'(32'h4000_0000);
    localparam coord_t C_ZERO = coord_t'(0);
    localparam coord_t C_ONE  = coord_t'(1);

    // weld predictor and store of expected result words
    class weld_scoreboard;
        vertex_t      vertices [MAX_VERTICES];
        int unsigned  stored;
        tol_t         tolerance;
        weld_result_t pending_welds [$];
        int unsigned  mismatches;

        function new();
            stored     = 0;
            tolerance  = '0;
            mismatches = 0;
        endfunction

        function u64_t axis_gap(coord_t a, coord_t b);
            longint d;
            d = longint'(a) - longint'(b);
            if (d < 0)
                d = -d;
            return u64_t'(d);
        endfunction

        // per-axis reject first, so the squared sum stays inside 64 bits
        function bit within_reach(int unsigned i, coord_t x, coord_t y, coord_t z);
            u64_t t, dx, dy, dz;
            t  = u64_t'(tolerance);
            dx = axis_gap(vertices[i].x, x);
            dy = axis_gap(vertices[i].y, y);
            dz = axis_gap(vertices[i].z, z);
            if (dx > t || dy > t || dz > t)
                return 1'b0;
            return (dx * dx + dy * dy + dz * dz) <= t * t;
        endfunction

        function weld_result_t predict_weld(coord_t x, coord_t y, coord_t z, logic merge);
            weld_result_t r;
            int unsigned  i;
            r.vertex_index = '0;
            r.is_new       = 1'b0;
            r.store_full   = 1'b0;
            // first near vertex in index order wins
            if (merge)
                for (i = 0; i < stored; i++)
                    if (within_reach(i, x, y, z))
                    begin
                        r.vertex_index = idx_out_t'(i);
                        return r;
                    end
            if (stored >= MAX_VERTICES)
            begin
                r.store_full = 1'b1;
                return r;
            end
            vertices[stored].x = x;
            vertices[stored].y = y;
            vertices[stored].z = z;
            r.vertex_index     = idx_out_t'(stored);
            r.is_new           = 1'b1;
            stored++;
            return r;
        endfunction

        function void note_vertex(coord_t x, coord_t y, coord_t z, logic merge);
            pending_welds.insert(pending_welds.size(), predict_weld(x, y, z, merge));
        endfunction

        function void check_result(idx_out_t idx, logic fresh, logic full);
            weld_result_t e;
            if (pending_welds.size() == 0)
            begin
                $error("result word with no vertex waiting: vertex_index %0d", idx);
                mismatches++;
                return;
            end
            e = pending_welds.pop_front();
            if (idx !== e.vertex_index)
            begin
                $error("vertex_index: expected %0d, actual %0d", e.vertex_index, idx);
                mismatches++;
            end
            if (fresh !== e.is_new)
            begin
                $error("is_new: expected %0b, actual %0b", e.is_new, fresh);
                mismatches++;
            end
            if (full !== e.store_full)
            begin
                $error("store_full: expected %0b, actual %0b", e.store_full, full);
                mismatches++;
            end
        endfunction
    endclass

    logic     clk = 1'b0;
    logic     rst_n;
    logic     cfg_valid;
    logic     cfg_ready;
    tol_t     cfg_data;
    logic     in_valid;
    logic     in_ready;
    coord_t   pos_x;
    coord_t   pos_y;
    coord_t   pos_z;
    logic     merge_enable;
    logic     out_valid;
    logic     out_ready = 1'b0;
    idx_out_t vertex_index;
    logic     is_new;
    logic     store_full;
    bit       idling;

    weld_scoreboard sb = new();

    tolerance_vertex_weld_table u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .merge_enable (merge_enable),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .vertex_index (vertex_index),
        .is_new       (is_new),
        .store_full   (store_full)
    );

    always #1 clk = ~clk;

    // result side back-pressure
    always @(negedge clk)
        out_ready <= !idling || ($urandom_range(0, 99) >= 12);

    // watch all three channels; results are checked before the new word is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(vertex_index, is_new, store_full);
            if (in_valid && in_ready)
                sb.note_vertex(pos_x, pos_y, pos_z, merge_enable);
            if (cfg_valid && cfg_ready)
                sb.tolerance = cfg_data;
        end
    end

    // driver tasks start and end at a falling edge
    task automatic send_vertex(input coord_t x, input coord_t y, input coord_t z,
                               input logic merge);
        while (idling && $urandom_range(0, 99) < 12)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        pos_x        <= x;
        pos_y        <= y;
        pos_z        <= z;
        merge_enable <= merge;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic drain_welds();
        in_valid <= 1'b0;
        while (sb.pending_welds.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_tolerance(input tol_t t);
        drain_welds();
        cfg_data  <= t;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic coord_t any_coord();
        return coord_t'($urandom);
    endfunction

    // offset within plus or minus r, wrapping at the coordinate width
    function automatic coord_t nudge(coord_t base, u64_t r);
        longint off;
        off = longint'($urandom_range(0, 32'(2 * r))) - longint'(r);
        return coord_t'(longint'(base) + off);
    endfunction

    // around the tolerance, half of it, just past it, or tiny
    function automatic u64_t reach_radius(tol_t t);
        u64_t r;
        case ($urandom_range(0, 3))
            0:       r = u64_t'(t);
            1:       r = u64_t'(t) / 2;
            2:       r = u64_t'(t) + 2;
            default: r = u64_t'($urandom_range(0, 3));
        endcase
        if (r > 64'h7FFF_FFFF)
            r = 64'h7FFF_FFFF;
        return r;
    endfunction

    // mostly copies and near neighbours of stored vertices, some pure noise
    task automatic random_vertex();
        int unsigned pick;
        int unsigned slot;
        vertex_t     base;
        u64_t        r;
        pick = $urandom_range(0, 99);
        if (sb.stored == 0 || pick < 15)
            send_vertex(any_coord(), any_coord(), any_coord(), $urandom_range(0, 1) != 0);
        else
        begin
            slot = $urandom_range(0, sb.stored - 1);
            base = sb.vertices[slot];
            r    = reach_radius(sb.tolerance);
            if (pick < 30)
                send_vertex(base.x, base.y, base.z, 1'b1);
            else
                send_vertex(nudge(base.x, r), nudge(base.y, r), nudge(base.z, r), pick < 85);
        end
    endtask

    initial
    begin
        tol_t        phase_tol [7];
        int unsigned phase;
        int unsigned n;

        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        pos_x        = '0;
        pos_y        = '0;
        pos_z        = '0;
        merge_enable = 1'b0;
        idling       = 1'b1;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // exact matching at the reset tolerance, empty store, duplicates, extremes
        send_vertex(C_ZERO, C_ZERO, C_ZERO, 1'b1);
        send_vertex(C_ZERO, C_ZERO, C_ZERO, 1'b1);
        send_vertex(C_ZERO, C_ZERO, C_ZERO, 1'b0);
        send_vertex(C_ZERO, C_ZERO, C_ONE, 1'b1);
        send_vertex(C_MIN, C_MIN, C_MIN, 1'b1);
        send_vertex(C_MAX, C_MAX, C_MAX, 1'b1);
        send_vertex(C_MIN, C_MAX, C_MIN, 1'b1);
        send_vertex(C_MAX, C_MAX, C_MAX, 1'b1);
        send_vertex(C_MIN, C_MIN, C_MIN, 1'b1);
        send_vertex(C_ZERO, C_ZERO, C_ZERO, 1'b1);
        send_vertex(C_MAX, C_MAX, C_MAX, 1'b0);

        // widest tolerance: axis overflow rejects and the exact boundary
        write_tolerance(31'h7FFF_FFFF);
        send_vertex(C_MAX, C_MIN, C_ZERO, 1'b1);
        send_vertex(C_HALF, C_HALF, C_HALF, 1'b1);
        send_vertex(C_MAX, C_ZERO, C_ZERO, 1'b1);
        send_vertex(C_MAX, C_ONE, C_ZERO, 1'b1);
        send_vertex(C_MIN, C_ZERO, C_ZERO, 1'b1);
        send_vertex(-C_HALF, -C_HALF, C_HALF, 1'b1);

        // tolerance of one lsb
        write_tolerance(31'h1);
        send_vertex(C_ONE, C_ZERO, C_ZERO, 1'b1);
        send_vertex(C_ONE, C_ONE, C_ZERO, 1'b1);
        send_vertex(C_ONE, C_ONE, C_ZERO, 1'b1);
        send_vertex(C_MAX - 1, C_MAX, C_MAX, 1'b1);

        // random phases over a spread of tolerances, one without idling
        phase_tol    = '{31'h0001_0000, 31'h0, 31'h7FFF_FFFF, 31'h1, 31'h0,
                         31'h0000_0400, 31'h0};
        phase_tol[4] = tol_t'($urandom);
        phase_tol[6] = tol_t'($urandom_range(0, 32'h0003_FFFF));
        for (phase = 0; phase < 7; phase++)
        begin
            idling = (phase != 2);
            write_tolerance(phase_tol[phase]);
            for (n = 0; n < 80; n++)
            begin
                if (phase == 1 && n == 40)
                    drain_welds();
                random_vertex();
            end
        end
        idling = 1'b1;

        drain_welds();
        if (sb.mismatches == 0 && sb.pending_welds.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // hang guard
    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
